[rtl/swrc_pkg.sv]
// Shared constants and types for the sliding-window repeat counter.
package swrc_pkg;

    localparam int SYMBOL_W       = 8;
    localparam int WIN_LEN_W      = 6;
    localparam int HIT_TOTAL_W    = 16;
    localparam int WINDOW_MAX_DEF = 32;

    localparam logic [WIN_LEN_W-1:0]   WIN_LEN_RESET = WIN_LEN_W'(8);
    localparam logic [HIT_TOTAL_W-1:0] HIT_TOTAL_MAX = '1;

    // Per-word control handed from the top level to the window store.
    typedef struct packed {
        logic step;   // a word is processed in this cycle
        logic clear;  // the word empties the window before it is checked
    } swrc_ctrl_t;

endpackage

[rtl/swrc_in_if.sv]
// Input channel: one symbol word with its first-of-case flag.
interface swrc_in_if;
    logic                          valid;
    logic                          ready;
    logic [swrc_pkg::SYMBOL_W-1:0] symbol;
    logic                          first_of_case;

    modport source (output valid, output symbol, output first_of_case, input ready);
    modport sink (input valid, input symbol, input first_of_case, output ready);
endinterface

[rtl/swrc_out_if.sv]
// Output channel: the hit flag and the running hit total.
interface swrc_out_if;
    logic                             valid;
    logic                             ready;
    logic                             hit;
    logic [swrc_pkg::HIT_TOTAL_W-1:0] hit_total;

    modport source (output valid, output hit, output hit_total, input ready);
    modport sink (input valid, input hit, input hit_total, output ready);
endinterface

[rtl/swrc_window.sv]
// Window store: a row of symbol registers with one comparator per entry and a fill count.
module swrc_window #(
    parameter int WINDOW_MAX = swrc_pkg::WINDOW_MAX_DEF,
    parameter int CNT_W      = $clog2(WINDOW_MAX + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swrc_pkg::swrc_ctrl_t          ctrl,
    input  logic [swrc_pkg::SYMBOL_W-1:0] symbol,
    input  logic [CNT_W-1:0]              eff_len,
    output logic                          hit
);

    logic [swrc_pkg::SYMBOL_W-1:0] entry_reg [WINDOW_MAX];
    logic [CNT_W-1:0]              fill_reg;
    logic [CNT_W-1:0]              fill_next;
    logic [CNT_W-1:0]              fill_now;
    logic [CNT_W-1:0]              wr_pos;
    logic [WINDOW_MAX-1:0]         match;
    logic                          grow;
    logic                          shift;

    // A clearing word sees an empty window.
    assign fill_now = ctrl.clear ? '0 : fill_reg;
    assign grow     = (eff_len != '0) && (fill_now < eff_len);
    assign shift    = (eff_len != '0) && !grow && (fill_now != '0);
    assign wr_pos   = grow ? fill_now : fill_now - CNT_W'(1);

    assign hit = |match;

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_entry
        logic [swrc_pkg::SYMBOL_W-1:0] upper;
        logic [swrc_pkg::SYMBOL_W-1:0] entry_next;
        logic                          take_upper;

        if (i < WINDOW_MAX - 1)
        begin : g_mid
            assign upper      = entry_reg[i+1];
            assign take_upper = shift && (CNT_W'(i + 1) < fill_now);
        end
        else
        begin : g_last
            assign upper      = entry_reg[i];
            assign take_upper = 1'b0;
        end

        assign match[i] = (entry_reg[i] == symbol) && (CNT_W'(i) < fill_now);

        always_comb
        begin
            entry_next = entry_reg[i];
            if (take_upper)
            begin
                entry_next = upper;
            end
            else if ((grow || shift) && (wr_pos == CNT_W'(i)))
            begin
                entry_next = symbol;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctrl.step)
            begin
                entry_reg[i] <= entry_next;
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (ctrl.step)
        begin
            fill_next = grow ? fill_now + CNT_W'(1) : fill_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW_MAX))
        else $error("window fill count beyond store depth");

    a_fill_no_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step && !ctrl.clear |=> fill_reg >= $past(fill_reg))
        else $error("window shrank without a clear");

endmodule

[rtl/sliding_window_repeat_counter_unit.sv]
// Top level of the sliding-window repeat counter: input register, window, hit counter, result register.
// An accepted word passes from the input register to the result register, which drives the output.
// Throughput: one word per cycle, sustained while the output side takes each result.
// The per-word path is the parallel compare across all window entries plus the fill-count update.
// Reset (rst_n, asynchronous, active low) empties the window, zeroes the hit total, sets the
// window length to 8 and drops any word in flight. No clearing pass is needed after reset.
module sliding_window_repeat_counter_unit #(
    parameter int WINDOW_MAX = swrc_pkg::WINDOW_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    swrc_in_if.sink                        in_ch,
    swrc_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [swrc_pkg::WIN_LEN_W-1:0] cfg_wdata
);

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (CNT_W > swrc_pkg::WIN_LEN_W) ? CNT_W : swrc_pkg::WIN_LEN_W;

    // Window length register; the user must write it only while the block is idle (not enforced here).
    logic [swrc_pkg::WIN_LEN_W-1:0] win_len_reg;
    logic [swrc_pkg::WIN_LEN_W-1:0] win_len_next;
    logic [CMP_W-1:0]               len_ext;
    logic [CMP_W-1:0]               max_ext;
    logic [CNT_W-1:0]               eff_len;

    // Input register stage.
    logic                          in_vld_reg;
    logic                          in_vld_next;
    logic [swrc_pkg::SYMBOL_W-1:0] sym_reg;
    logic                          first_reg;
    logic                          in_take;

    // Result stage.
    logic                             out_vld_reg;
    logic                             out_vld_next;
    logic                             out_hit_reg;
    logic                             out_hit_next;
    logic [swrc_pkg::HIT_TOTAL_W-1:0] hit_cnt_reg;
    logic [swrc_pkg::HIT_TOTAL_W-1:0] hit_cnt_next;
    logic [swrc_pkg::HIT_TOTAL_W-1:0] cnt_base;

    logic                 advance;
    logic                 win_hit;
    swrc_pkg::swrc_ctrl_t win_ctrl;

    // A window length beyond the store depth behaves as the full store.
    assign len_ext = CMP_W'(win_len_reg);
    assign max_ext = CMP_W'(WINDOW_MAX);
    assign eff_len = (len_ext > max_ext) ? CNT_W'(max_ext) : CNT_W'(len_ext);

    // The word in the input register moves on whenever the result register is free or is being
    // emptied in this cycle, so words pass back to back. While a result waits downstream the
    // input register takes one more word and the input side then stalls.
    assign advance     = in_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready = !in_vld_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    assign win_ctrl.step  = advance;
    assign win_ctrl.clear = first_reg;

    swrc_window #(
        .WINDOW_MAX (WINDOW_MAX),
        .CNT_W      (CNT_W)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (win_ctrl),
        .symbol  (sym_reg),
        .eff_len (eff_len),
        .hit     (win_hit)
    );

    // The hit count restarts from zero on a first-of-case word and sticks at its maximum.
    assign cnt_base = first_reg ? '0 : hit_cnt_reg;

    always_comb
    begin
        win_len_next = cfg_we ? cfg_wdata : win_len_reg;
        in_vld_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        out_vld_next = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_reg);
        out_hit_next = out_hit_reg;
        hit_cnt_next = hit_cnt_reg;
        if (advance)
        begin
            out_hit_next = win_hit;
            hit_cnt_next = (win_hit && (cnt_base != swrc_pkg::HIT_TOTAL_MAX))
                         ? cnt_base + swrc_pkg::HIT_TOTAL_W'(1) : cnt_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg <= swrc_pkg::WIN_LEN_RESET;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            hit_cnt_reg <= '0;
        end
        else
        begin
            win_len_reg <= win_len_next;
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            hit_cnt_reg <= hit_cnt_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sym_reg   <= in_ch.symbol;
            first_reg <= in_ch.first_of_case;
        end
        out_hit_reg <= out_hit_next;
    end

    assign out_ch.valid     = out_vld_reg;
    assign out_ch.hit       = out_hit_reg;
    assign out_ch.hit_total = hit_cnt_reg;

    a_case_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && first_reg |=> hit_cnt_reg <= swrc_pkg::HIT_TOTAL_W'(1))
        else $error("hit total not restarted by first-of-case word");

    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_hit_reg |-> hit_cnt_reg != '0)
        else $error("hit reported with a zero hit total");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !first_reg |=> hit_cnt_reg >= $past(hit_cnt_reg))
        else $error("hit total fell without a clear");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_ch.ready |-> !advance)
        else $error("result overwritten while stalled");

endmodule
